@@ sv/bcdexp_pkg.sv @@
// ----------------------------------------------------------------------------
// bcdexp_pkg
// Shared types and constants for the binary to packed BCD export block.
// ----------------------------------------------------------------------------
package bcdexp_pkg;

	// Default sizing
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int MAX_BYTES_DEF   = 8;

	// Fixed field widths
	localparam int VALUE_BITS = 32;
	localparam int COUNT_BITS = 4;
	localparam int INDEX_BITS = 3;

	// Fill byte for buffer positions past the needed digits
	localparam logic [7:0] PAD_BYTE = 8'hFF;

	// Input item
	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic [COUNT_BITS-1:0] byte_count;
	} req_t;

	// Result item, one per buffer byte
	typedef struct packed {
		logic [INDEX_BITS-1:0] byte_index;
		logic [7:0]            bcd_byte;
		logic                  is_padding;
		logic                  last;
	} rsp_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIZE,
		ST_EMIT
	} state_t;

endpackage

@@ sv/binary_to_packed_bcd_export.sv @@
// ----------------------------------------------------------------------------
// binary_to_packed_bcd_export
// Converts an unsigned value to packed BCD and streams it out as a buffer of
// byte_count bytes, most significant byte first, padded with 0xFF.
// ----------------------------------------------------------------------------
// An item is converted in ST_CONV, sized in ST_SIZE and emitted in ST_EMIT;
// req_ready returns in the cycle after its last byte is loaded into the
// output register, or after ST_SIZE when it has no bytes, so a new item is
// accepted only once the previous one is done. A single shift-add-3 (double
// dabble) unit handles one input bit per cycle, ST_SIZE sizes the digit
// count, and ST_EMIT loads one output byte per cycle whenever the output
// register is free or being read; req_ready is low for the whole of that
// time. The last byte may still wait in the output register while the next
// item is accepted. A byte_count of zero gives no bytes, and a byte_count
// above MAX_BYTES is treated as MAX_BYTES. When the buffer is shorter than
// the digit pairs needed, high-order digits drop out.
// ----------------------------------------------------------------------------
module binary_to_packed_bcd_export #(
	parameter int VALUE_WIDTH = bcdexp_pkg::VALUE_WIDTH_DEF,
	parameter int MAX_BYTES   = bcdexp_pkg::MAX_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  bcdexp_pkg::req_t  req_data,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output bcdexp_pkg::rsp_t  rsp_data
);

	// Decimal digits that cover 2**VALUE_WIDTH - 1, grouped in byte pairs
	localparam int ND = ((VALUE_WIDTH * 1233) >> 12) + 1;
	localparam int NP = (ND + 1) / 2;
	localparam int DW = 8 * NP;
	localparam int KW = (NP > 1) ? $clog2(NP) : 1;
	localparam int NW = $clog2(NP + 1);
	localparam int LW = $clog2(MAX_BYTES + 1);
	localparam int CW = (NW > LW) ? NW : LW;
	localparam int SW = $clog2(VALUE_WIDTH + 1);

	bcdexp_pkg::state_t state_q, state_d;

	logic [VALUE_WIDTH-1:0] val_in;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [DW-1:0]          bcd_q;
	logic [DW-1:0]          bcd_adj;
	logic [DW-1:0]          bcd_next;
	logic [SW-1:0]          step_q;
	logic [LW-1:0]          len_q;
	logic [LW-1:0]          len_sat;
	logic [LW-1:0]          used_q;
	logic [LW-1:0]          used_c;
	logic [LW-1:0]          idx_q;
	logic [NW-1:0]          need_c;
	logic [CW-1:0]          kdiff;
	logic [KW-1:0]          k_c;
	logic                   pad_c;
	logic                   last_c;
	logic                   accept;
	logic                   conv_en;
	logic                   size_en;
	logic                   load;
	logic                   rsp_valid_q;
	bcdexp_pkg::rsp_t       rsp_q;

	// Bring the input value to the working width
	generate
		if (VALUE_WIDTH <= bcdexp_pkg::VALUE_BITS) begin : g_trunc
			assign val_in = req_data.value[VALUE_WIDTH-1:0];
		end else begin : g_ext
			assign val_in = {{(VALUE_WIDTH - bcdexp_pkg::VALUE_BITS){1'b0}}, req_data.value};
		end
	endgenerate

	// Saturate buffer length
	assign len_sat = (5'(req_data.byte_count) > 5'(MAX_BYTES)) ? LW'(MAX_BYTES)
		: LW'(req_data.byte_count);

	assign accept = req_valid && req_ready;

	// Shift-add-3 step: correct every digit, then shift in the next value bit
	always_comb begin
		bcd_adj = bcd_q;
		for (int d = 0; d < 2 * NP; d++) begin
			if (bcd_q[4*d +: 4] >= 4'd5) begin
				bcd_adj[4*d +: 4] = bcd_q[4*d +: 4] + 4'd3;
			end
		end
		bcd_next = {bcd_adj[DW-2:0], val_q[VALUE_WIDTH-1]};
	end

	// Digit pairs needed: highest nonzero pair, zero still takes one
	always_comb begin
		need_c = NW'(1);
		for (int p = 0; p < NP; p++) begin
			if (|bcd_q[8*p +: 8]) begin
				need_c = NW'(p + 1);
			end
		end
		used_c = (CW'(need_c) < CW'(len_q)) ? LW'(need_c) : len_q;
	end

	// Byte selection for the current buffer position
	assign kdiff  = CW'(used_q) - CW'(idx_q) - CW'(1);
	assign k_c    = KW'(kdiff);
	assign pad_c  = (idx_q >= used_q);
	assign last_c = (LW'(idx_q + LW'(1)) == len_q);

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bcdexp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and control
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		conv_en   = 1'b0;
		size_en   = 1'b0;
		load      = 1'b0;
		case (state_q)
			bcdexp_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = bcdexp_pkg::ST_CONV;
				end
			end
			bcdexp_pkg::ST_CONV: begin
				conv_en = 1'b1;
				if (step_q == SW'(VALUE_WIDTH - 1)) begin
					state_d = bcdexp_pkg::ST_SIZE;
				end
			end
			bcdexp_pkg::ST_SIZE: begin
				size_en = 1'b1;
				if (len_q == '0) begin
					state_d = bcdexp_pkg::ST_IDLE;
				end else begin
					state_d = bcdexp_pkg::ST_EMIT;
				end
			end
			bcdexp_pkg::ST_EMIT: begin
				if (!rsp_valid_q || rsp_ready) begin
					load = 1'b1;
					if (last_c) begin
						state_d = bcdexp_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = bcdexp_pkg::ST_IDLE;
			end
		endcase
	end

	// Counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				step_q <= '0;
				idx_q  <= '0;
			end else begin
				if (conv_en) begin
					step_q <= step_q + SW'(1);
				end
				if (load) begin
					idx_q <= idx_q + LW'(1);
				end
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Working value, digits and output byte
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= val_in;
			bcd_q <= '0;
			len_q <= len_sat;
		end else if (conv_en) begin
			val_q <= {val_q[VALUE_WIDTH-2:0], 1'b0};
			bcd_q <= bcd_next;
		end
		if (size_en) begin
			used_q <= used_c;
		end
		if (load) begin
			rsp_q.byte_index <= bcdexp_pkg::INDEX_BITS'(idx_q);
			rsp_q.bcd_byte   <= pad_c ? bcdexp_pkg::PAD_BYTE : bcd_q[k_c*8 +: 8];
			rsp_q.is_padding <= pad_c;
			rsp_q.last       <= last_c;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// Checks
	a_pad_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.is_padding |-> rsp_data.bcd_byte == bcdexp_pkg::PAD_BYTE)
		else $error("padding byte is not 0xFF");

	a_bcd_digits: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.is_padding |->
		rsp_data.bcd_byte[7:4] <= 4'd9 && rsp_data.bcd_byte[3:0] <= 4'd9)
		else $error("digit byte holds a non-decimal nibble");

	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bcdexp_pkg::ST_EMIT |-> idx_q < len_q)
		else $error("byte position past buffer length");

	a_accept_conv: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> state_q == bcdexp_pkg::ST_CONV && !req_ready)
		else $error("accepted item did not start conversion");

endmodule

@@ verif/binary_to_packed_bcd_export_tb.sv @@
// ----------------------------------------------------------------------------
// binary_to_packed_bcd_export_tb
// Streams binary values with buffer lengths into the packed BCD exporter and
// checks every emitted byte against a behavioral prediction of the buffer:
// digit pairs most significant first, dropped high digits on short buffers,
// 0xFF fill, index and last flags. Runs under several idle/stall mixes.
// ----------------------------------------------------------------------------
module binary_to_packed_bcd_export_tb;

	localparam int MAX_BYTES      = bcdexp_pkg::MAX_BYTES_DEF;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 60;
	localparam int MAX_REPORTS    = 10;

	logic clk;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	bcdexp_pkg::req_t req_data = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	bcdexp_pkg::rsp_t rsp_data;

	// expected buffer bytes, oldest first
	bcdexp_pkg::rsp_t expected_bytes[$];
	int   mismatch_count = 0;
	int   idle_pct       = 0;
	int   stall_pct      = 0;
	int   quiet_cycles   = 0;

	binary_to_packed_bcd_export dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Ten decimal digits of a 32-bit value, digit 0 in the low nibble
	function automatic logic [39:0] decimal_digits(input logic [31:0] v);
		logic [39:0] digits;
		logic [31:0] rest;
		int k;
		digits = '0;
		rest = v;
		for (k = 0; k < 10; k++) begin
			digits[k*4 +: 4] = 4'(rest % 10);
			rest = rest / 10;
		end
		return digits;
	endfunction

	// Builds the buffer one value produces and queues its bytes
	task automatic predict_buffer(input bcdexp_pkg::req_t item);
		int unsigned len, ndigits, need, used, i;
		logic [39:0] digits;
		logic [31:0] rest;
		bcdexp_pkg::rsp_t b;
		len = item.byte_count;
		if (len > MAX_BYTES)
			len = MAX_BYTES;
		digits = decimal_digits(item.value);
		ndigits = 1;
		rest = item.value;
		while (rest >= 10) begin
			rest = rest / 10;
			ndigits++;
		end
		need = (ndigits + 1) / 2;
		used = (len < need) ? len : need;
		for (i = 0; i < len; i++) begin
			b.byte_index = 3'(i);
			b.bcd_byte   = (i < used) ? digits[(used - 1 - i)*8 +: 8]
				: bcdexp_pkg::PAD_BYTE;
			b.is_padding = (i >= used);
			b.last       = (i + 1 == len);
			expected_bytes.push_back(b);
		end
	endtask

	// Sends one item, then idles at random per the current sender mix
	task automatic send_item(input logic [31:0] value, input logic [3:0] count);
		bcdexp_pkg::req_t item;
		item.value = value;
		item.byte_count = count;
		req_valid <= 1'b1;
		req_data <= item;
		do @(posedge clk); while (!req_ready);
		predict_buffer(item);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	// Values spread over all digit counts, some fully random
	function automatic logic [31:0] random_value();
		int unsigned ndigits;
		logic [63:0] lo, hi;
		if ($urandom_range(3) == 0)
			return $urandom();
		ndigits = $urandom_range(1, 10);
		lo = 1;
		repeat (ndigits - 1) lo = lo * 10;
		hi = lo * 10 - 1;
		if (ndigits == 1)
			lo = 0;
		if (hi > 64'hFFFF_FFFF)
			hi = 64'hFFFF_FFFF;
		return 32'(lo + ($urandom() % (hi - lo + 1)));
	endfunction

	// Mostly legal lengths, some zero and oversize
	function automatic logic [3:0] random_count();
		if ($urandom_range(99) < 8)
			return 4'($urandom_range(0, 15));
		return 4'($urandom_range(1, 8));
	endfunction

	// Receiver stall pattern
	always @(posedge clk)
		rsp_ready <= ($urandom_range(99) >= stall_pct);

	// Compare each emitted byte with the oldest expectation
	always @(posedge clk) begin
		bcdexp_pkg::rsp_t want;
		if (rsp_valid && rsp_ready) begin
			if (expected_bytes.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected byte: idx=%0d byte=%02h pad=%0b last=%0b",
						rsp_data.byte_index, rsp_data.bcd_byte,
						rsp_data.is_padding, rsp_data.last);
			end else begin
				want = expected_bytes.pop_front();
				if (rsp_data.byte_index !== want.byte_index ||
						rsp_data.bcd_byte !== want.bcd_byte ||
						rsp_data.is_padding !== want.is_padding ||
						rsp_data.last !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("mismatch: exp idx/byte/pad/last %0d/%02h/%0b/%0b",
							want.byte_index, want.bcd_byte, want.is_padding, want.last,
							", got %0d/%02h/%0b/%0b",
							rsp_data.byte_index, rsp_data.bcd_byte,
							rsp_data.is_padding, rsp_data.last);
				end
			end
		end
	end

	// Watchdog: cycles with no item moving on either side
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog timeout, %0d bytes outstanding", expected_bytes.size());
				$display("binary_to_packed_bcd_export_tb failed");
				$finish;
			end
		end
	end

	// Zero is one digit: a single 0x00 then fill
	task automatic test_zero_value();
		send_item(32'd0, 4'd1);
		send_item(32'd0, 4'd2);
		send_item(32'd0, 4'd8);
	endtask

	// Value extremes and bit patterns
	task automatic test_field_extremes();
		send_item(32'hFFFF_FFFF, 4'd5);
		send_item(32'hFFFF_FFFF, 4'd8);
		send_item(32'h8000_0000, 4'd7);
		send_item(32'hAAAA_AAAA, 4'd8);
		send_item(32'h5555_5555, 4'd6);
		send_item(32'd1, 4'd3);
	endtask

	// Zero length, oversize lengths, digit count boundaries
	task automatic test_length_edges();
		send_item(32'd12345, 4'd0);
		send_item(32'd67, 4'd1);
		send_item(32'd4321, 4'd9);
		send_item(32'hFFFF_FFFF, 4'd15);
		send_item(32'd9, 4'd12);
		send_item(32'd10, 4'd1);
		send_item(32'd99, 4'd2);
		send_item(32'd100, 4'd2);
		send_item(32'd999, 4'd3);
	endtask

	// Short buffers drop the high-order digits
	task automatic test_truncation();
		send_item(32'd1000, 4'd1);
		send_item(32'd99999, 4'd2);
		send_item(32'd1234567890, 4'd4);
		send_item(32'd123456789, 4'd3);
		send_item(32'hFFFF_FFFF, 4'd1);
	endtask

	task automatic test_random_mix(input int n, input int idle, input int stall);
		idle_pct = idle;
		stall_pct = stall;
		repeat (n) send_item(random_value(), random_count());
	endtask

	// Burst, then hold the sender until every byte is out
	task automatic test_pause_until_drained();
		repeat (4) send_item(random_value(), 4'($urandom_range(1, 8)));
		req_valid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		send_item(random_value(), 4'd8);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_zero_value();
		test_field_extremes();
		test_length_edges();
		test_truncation();
		test_random_mix(60, 0, 0);
		test_random_mix(60, 84, 0);
		test_pause_until_drained();
		test_random_mix(60, 0, 84);
		test_random_mix(60, 31, 31);

		req_valid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_bytes.size() == 0) begin
			$display("binary_to_packed_bcd_export_tb passed");
		end else begin
			$display("binary_to_packed_bcd_export_tb failed");
		end
		$finish;
	end

endmodule

@@ binary_to_packed_bcd_export.f @@
sv/bcdexp_pkg.sv
sv/binary_to_packed_bcd_export.sv
verif/binary_to_packed_bcd_export_tb.sv
